@@ hdl/circle_tessellation_generator_assert.svh @@
// Assertion macros for the circle tessellation generator.
// Used by circle_tessellation_generator.sv; expects aclk and aresetn in scope.
`ifndef CIRCLE_TESSELLATION_GENERATOR_ASSERT_SVH
`define CIRCLE_TESSELLATION_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ctg_pkg.sv @@
// Package for the circle tessellation generator: sequencer states, control
// bundle, register indexes, stream widths and fixed constants. No dependencies.
package ctg_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINE_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COSINE_STEP   = 2'd2;

    localparam logic [6:0]         SEG_COUNT_RESET = 7'd32;
    localparam logic signed [15:0] SINE_RESET      = 16'sd6393;
    localparam logic signed [15:0] COSINE_RESET    = 16'sd32138;
    localparam logic [6:0]         SEG_MIN         = 7'd3;

    // Step registers are Q1.15.
    localparam int STEP_FRAC = 15;

    // Stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_PAD_W   = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT_A,
        ST_ROT_B,
        ST_ROT_C,
        ST_ROT_D,
        ST_ROT_E,
        ST_VTX_X,
        ST_VTX_Y,
        ST_EMIT
    } ctg_state_t;

    typedef enum logic [2:0] {
        MUL_COS_RX,
        MUL_SIN_RY,
        MUL_SIN_RX,
        MUL_COS_RY,
        MUL_RAD_NX,
        MUL_RAD_NY
    } ctg_mul_sel_t;

    typedef struct packed {
        ctg_mul_sel_t mul_sel;
        logic         load_prod;
        logic         load_acc;
        logic         load_nx;
        logic         load_ny;
        logic         load_ex;
        logic         load_ey;
        logic         rot_sub;
        logic         vtx_use_y;
    } ctg_ctl_t;

endpackage

@@ hdl/circle_tessellation_generator.sv @@
// Circle tessellation generator: top level and its only module. Uses ctg_pkg
// and the assertion macros in circle_tessellation_generator_assert.svh.
//
// One circle request is taken on the s_ stream (centre, radius, colour in
// s_tdata, fill mode in s_tuser). The block then turns a unit vector from
// (1,0) by the programmed sine and cosine step once per segment and emits
// one beat per rim segment on the m_ stream, with m_tlast on the final one.
// Segment count, sine and cosine step are set through the cfg_ write port; the
// user must write them only while no circle is in flight, as the block does not enforce it.
//
// A single signed multiplier, reused under a small sequencer, forms the four
// rotation products and the two radius products of each segment. s_tready is
// low after the request beat until the sequencer hands the final segment of
// the circle to the output register and returns to idle, so no new request
// is taken while a circle is in flight.
// The output beat sits in its own register, so work on the next segment
// carries on while the receiver stalls; the sequencer only waits when a new
// segment is ready and the previous beat has still not been taken.
// Reset returns the step registers to their defaults, drops any circle in
// flight and clears m_tvalid.
module circle_tessellation_generator #(
    parameter int MAX_SEGMENTS  = 64,
    parameter int ROT_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ctg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // center_x[15:0], center_y[31:16], radius[46:32], color_rgba[78:47], zero pad
    input  logic [ctg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // fill_mode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // start_x[16:0], start_y[33:17], end_x[50:34], end_y[67:51], hub_x[83:68],
    // hub_y[99:84], color_out[131:100], zero pad
    output logic [ctg_pkg::OUT_TDATA_W-1:0] m_tdata,
    // fan_triangle
    output logic                            m_tuser,
    // last_segment
    output logic                            m_tlast
);
    import ctg_pkg::*;

    localparam int RW = ROT_FRAC_BITS + 2;             // rotation vector width
    localparam int PW = 16 + RW;                        // product width
    localparam int SW = PW + 1;                         // rotation sum width
    localparam int HW = SW - STEP_FRAC;                 // rotation sum after shift
    localparam int VW = PW + 2 - ROT_FRAC_BITS;         // vertex sum width
    localparam int KW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [6:0] SegMax = 7'(MAX_SEGMENTS);

    ctg_state_t state_reg, state_next;
    ctg_ctl_t   ctl;
    logic       emit_go;
    logic       seg_last;

    logic [6:0]         segcnt_reg;
    logic signed [15:0] sine_reg, cosine_reg;

    logic signed [15:0] cx_reg, cy_reg;
    logic [14:0]        rad_reg;
    logic [31:0]        color_reg;
    logic               fill_reg;

    logic signed [RW-1:0] rx_reg, ry_reg, nx_reg, ny_reg;
    logic signed [16:0]   sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] acc_reg;
    logic [KW-1:0]        seg_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg, m_tlast_reg;

    logic [6:0]           seg_n, seg_n_m1;
    logic signed [15:0]   mul_a;
    logic signed [RW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [SW-1:0] rot_sum;
    logic signed [HW-1:0] rot_sh;
    logic signed [RW-1:0] rot_sat;
    logic signed [PW:0]   vtx_rnd_sum;
    logic signed [VW-1:0] vtx_sum;
    logic signed [16:0]   vtx_sat;
    logic signed [15:0]   vtx_center;

    // ------------------------------------------------------------------
    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segcnt_reg <= SEG_COUNT_RESET;
            sine_reg   <= SINE_RESET;
            cosine_reg <= COSINE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SEGMENT_COUNT: segcnt_reg <= cfg_wdata[6:0];
                REG_SINE_STEP:     sine_reg   <= signed'(cfg_wdata);
                REG_COSINE_STEP:   cosine_reg <= signed'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Effective segment count, held within three and the maximum.
    always_comb begin
        if (segcnt_reg < SEG_MIN) begin
            seg_n = SEG_MIN;
        end else if (segcnt_reg > SegMax) begin
            seg_n = SegMax;
        end else begin
            seg_n = segcnt_reg;
        end
    end
    assign seg_n_m1 = seg_n - 7'd1;
    assign seg_last = (7'(seg_reg) == seg_n_m1);

    // The sequencer may only hand over a segment once the output slot is free.
    assign emit_go = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_ROT_A;
            ST_ROT_A: state_next = ST_ROT_B;
            ST_ROT_B: state_next = ST_ROT_C;
            ST_ROT_C: state_next = ST_ROT_D;
            ST_ROT_D: state_next = ST_ROT_E;
            ST_ROT_E: state_next = ST_VTX_X;
            ST_VTX_X: state_next = ST_VTX_Y;
            ST_VTX_Y: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_go) state_next = seg_last ? ST_IDLE : ST_ROT_A;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: control decode.
    always_comb begin
        ctl      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_ROT_A: begin
                ctl.mul_sel   = MUL_COS_RX;
                ctl.load_prod = 1'b1;
            end
            ST_ROT_B: begin
                ctl.mul_sel   = MUL_SIN_RY;
                ctl.load_prod = 1'b1;
                ctl.load_acc  = 1'b1;
            end
            ST_ROT_C: begin
                ctl.mul_sel   = MUL_SIN_RX;
                ctl.load_prod = 1'b1;
                ctl.load_nx   = 1'b1;
                ctl.rot_sub   = 1'b1;
            end
            ST_ROT_D: begin
                ctl.mul_sel   = MUL_COS_RY;
                ctl.load_prod = 1'b1;
                ctl.load_acc  = 1'b1;
            end
            ST_ROT_E: begin
                ctl.mul_sel   = MUL_RAD_NX;
                ctl.load_prod = 1'b1;
                ctl.load_ny   = 1'b1;
            end
            ST_VTX_X: begin
                ctl.mul_sel   = MUL_RAD_NY;
                ctl.load_prod = 1'b1;
                ctl.load_ex   = 1'b1;
            end
            ST_VTX_Y: begin
                ctl.load_ey   = 1'b1;
                ctl.vtx_use_y = 1'b1;
            end
            ST_EMIT:  ;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier.
    always_comb begin
        case (ctl.mul_sel)
            MUL_COS_RX: begin mul_a = cosine_reg; mul_b = rx_reg; end
            MUL_SIN_RY: begin mul_a = sine_reg;   mul_b = ry_reg; end
            MUL_SIN_RX: begin mul_a = sine_reg;   mul_b = rx_reg; end
            MUL_COS_RY: begin mul_a = cosine_reg; mul_b = ry_reg; end
            MUL_RAD_NX: begin mul_a = signed'({1'b0, rad_reg}); mul_b = nx_reg; end
            MUL_RAD_NY: begin mul_a = signed'({1'b0, rad_reg}); mul_b = ny_reg; end
            default:    begin mul_a = cosine_reg; mul_b = rx_reg; end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Rotation: the accumulator already carries the rounding half, so the
    // sum only needs an arithmetic shift and a range check.
    assign rot_sum = ctl.rot_sub ? (acc_reg - SW'(prod_reg)) : (acc_reg + SW'(prod_reg));
    assign rot_sh  = rot_sum[SW-1:STEP_FRAC];
    always_comb begin
        if ((&rot_sh[HW-1:RW-1]) || !(|rot_sh[HW-1:RW-1])) begin
            rot_sat = rot_sh[RW-1:0];
        end else if (rot_sh[HW-1]) begin
            rot_sat = {1'b1, {(RW-1){1'b0}}};
        end else begin
            rot_sat = {1'b0, {(RW-1){1'b1}}};
        end
    end

    // Rim vertex: centre plus the rounded radius product, held to 17 bits.
    // The shifted product is negative for half the rim, so it is widened by sign.
    assign vtx_center  = ctl.vtx_use_y ? cy_reg : cx_reg;
    assign vtx_rnd_sum = (PW+1)'(prod_reg) + ((PW+1)'(1) <<< (ROT_FRAC_BITS - 1));
    assign vtx_sum     = VW'(signed'(vtx_rnd_sum[PW:ROT_FRAC_BITS])) + VW'(vtx_center);
    always_comb begin
        if ((&vtx_sum[VW-1:16]) || !(|vtx_sum[VW-1:16])) begin
            vtx_sat = vtx_sum[16:0];
        end else if (vtx_sum[VW-1]) begin
            vtx_sat = {1'b1, 16'h0000};
        end else begin
            vtx_sat = {1'b0, 16'hFFFF};
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (ctl.load_prod) prod_reg <= mul_p;
        if (ctl.load_acc)  acc_reg  <= SW'(prod_reg) + (SW'(1) <<< (STEP_FRAC - 1));
        if (ctl.load_nx)   nx_reg   <= rot_sat;
        if (ctl.load_ny)   ny_reg   <= rot_sat;
        if (ctl.load_ex)   ex_reg   <= vtx_sat;
        if (ctl.load_ey)   ey_reg   <= vtx_sat;

        if (state_reg == ST_IDLE && s_tvalid) begin
            cx_reg    <= signed'(s_tdata[15:0]);
            cy_reg    <= signed'(s_tdata[31:16]);
            rad_reg   <= s_tdata[46:32];
            color_reg <= s_tdata[78:47];
            fill_reg  <= s_tuser;
            rx_reg    <= RW'(1) <<< ROT_FRAC_BITS;
            ry_reg    <= '0;
            // The first rim vertex is exact: radius times one, no rounding.
            sx_reg    <= 17'(signed'(s_tdata[15:0])) + 17'(s_tdata[46:32]);
            sy_reg    <= 17'(signed'(s_tdata[31:16]));
            seg_reg   <= '0;
        end else if (state_reg == ST_EMIT && emit_go) begin
            rx_reg  <= nx_reg;
            ry_reg  <= ny_reg;
            sx_reg  <= ex_reg;
            sy_reg  <= ey_reg;
            seg_reg <= seg_reg + KW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && emit_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && emit_go) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, color_reg, cy_reg, cx_reg,
                            ey_reg, ex_reg, sy_reg, sx_reg};
            m_tuser_reg <= fill_reg;
            m_tlast_reg <= seg_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    `include "circle_tessellation_generator_assert.svh"

    `CTG_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready,
                     "request taken but block still shows ready")
    `CTG_ASSERT_NOW(a_segment_in_range, state_reg != ST_IDLE, 7'(seg_reg) <= seg_n_m1,
                    "segment index ran past the segment count")
    `CTG_ASSERT_NEXT(a_last_ends_circle, state_reg == ST_EMIT && emit_go && seg_last,
                     s_tready && m_tvalid && m_tlast,
                     "final segment did not end the circle")
    `CTG_ASSERT_NEXT(a_emit_fills_slot, state_reg == ST_EMIT && emit_go, m_tvalid,
                     "segment handed over but no output beat")

endmodule
